>>> hw/rtl/cea_pkg.sv
// ============================================================================
// cea_pkg: shared types and constants of the effective-address unit
// Addressing mode codes, sequencer phases, request and result records.
// ============================================================================
package cea_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_FIX_WRAP = 1'b0;  // paddr[2] selects the register

    // Addressing modes, same codes as the mode field
    typedef enum logic [3:0] {
        MODE_IMP  = 4'd0,
        MODE_ACC  = 4'd1,
        MODE_IMM  = 4'd2,
        MODE_ZP   = 4'd3,
        MODE_ZPX  = 4'd4,
        MODE_ZPY  = 4'd5,
        MODE_ABS  = 4'd6,
        MODE_ABSX = 4'd7,
        MODE_ABSY = 4'd8,
        MODE_REL  = 4'd9,
        MODE_IND  = 4'd10,
        MODE_INDX = 4'd11,
        MODE_INDY = 4'd12
    } mode_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_OP1  = 3'd1,
        PH_OP2  = 3'd2,
        PH_PLO  = 3'd3,
        PH_PHI  = 3'd4,
        PH_VAL  = 3'd5
    } phase_t;

    // Request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // Result kinds
    localparam logic OUT_REQUEST = 1'b0;
    localparam logic OUT_DONE    = 1'b1;

    localparam logic [7:0]  SIGN_MASK = 8'h80;
    localparam logic [15:0] PAGE_MASK = 16'hFF00;
    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    typedef struct packed {
        logic        kind;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic        need_value;
        logic [7:0]  read_data;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] read_address;
        logic [15:0] effective_address;
        logic [15:0] operand_value;
        logic [15:0] next_pc;
        logic        page_crossed;
        logic [3:0]  mode_done;
    } result_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } core_status_t;

endpackage

>>> hw/rtl/cea_in_stage.sv
// ============================================================================
// cea_in_stage: input register
// Holds one accepted request until the sequencer core takes it.
// ============================================================================
module cea_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  cea_pkg::item_t  in_item,
    output logic            held_valid,
    output cea_pkg::item_t  held_item,
    input  logic            take
);

    logic           valid_reg;
    logic           valid_next;
    cea_pkg::item_t item_reg;
    logic           accept;

    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> hw/rtl/cea_core.sv
// ============================================================================
// cea_core: addressing-mode sequencer
// Holds the sequence state and computes the next state and result of a request.
// ============================================================================
module cea_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  cea_pkg::item_t        item,
    input  logic                  fix_wrap,
    output cea_pkg::result_t      res,
    output cea_pkg::core_status_t status
);

    cea_pkg::phase_t phase_reg, phase_next;
    cea_pkg::mode_t  held_mode_reg, held_mode_next;
    logic [15:0]     held_pc_reg, held_pc_next;
    logic [7:0]      held_x_reg, held_x_next;
    logic [7:0]      held_y_reg, held_y_next;
    logic            held_need_reg, held_need_next;
    logic [7:0]      low_byte_reg, low_byte_next;
    logic [15:0]     work_address_reg, work_address_next;
    logic            carry_reg, carry_next;

    cea_pkg::mode_t  m;
    logic            do_req;
    logic [15:0]     req_addr;
    logic            do_done;
    logic [15:0]     done_ea;
    logic [15:0]     done_val;
    logic            ar;
    logic [15:0]     ar_ea;
    logic [15:0]     base;
    logic [15:0]     sum16;
    logic [8:0]      sum9;
    logic [7:0]      b;
    logic [7:0]      hb;

    always_comb
    begin
        phase_next        = phase_reg;
        held_mode_next    = held_mode_reg;
        held_pc_next      = held_pc_reg;
        held_x_next       = held_x_reg;
        held_y_next       = held_y_reg;
        held_need_next    = held_need_reg;
        low_byte_next     = low_byte_reg;
        work_address_next = work_address_reg;
        carry_next        = carry_reg;
        m        = cea_pkg::MODE_IMP;
        do_req   = 1'b0;
        req_addr = '0;
        do_done  = 1'b0;
        done_ea  = '0;
        done_val = '0;
        ar       = 1'b0;
        ar_ea    = '0;
        base     = '0;
        sum16    = '0;
        sum9     = '0;
        hb       = '0;
        b        = item.read_data;

        if (fire)
        begin
            if (item.kind == cea_pkg::KIND_START)
            begin
                // Codes above the last mode are treated as implied.
                m = (item.mode > 4'(cea_pkg::MODE_INDY)) ? cea_pkg::MODE_IMP
                                                         : cea_pkg::mode_t'(item.mode);
                held_mode_next    = m;
                held_pc_next      = item.pc;
                held_x_next       = item.index_x;
                held_y_next       = item.index_y;
                held_need_next    = item.need_value;
                low_byte_next     = '0;
                work_address_next = '0;
                carry_next        = 1'b0;
                unique case (m)
                    cea_pkg::MODE_IMP:
                    begin
                        do_done = 1'b1;
                    end
                    cea_pkg::MODE_ACC:
                    begin
                        do_done  = 1'b1;
                        done_val = {8'h00, item.acc};
                    end
                    cea_pkg::MODE_IMM:
                    begin
                        work_address_next = item.pc;
                        if (!item.need_value)
                        begin
                            // Immediate without a fetch leaves PC where it was.
                            do_done = 1'b1;
                            done_ea = item.pc;
                        end
                        else
                        begin
                            phase_next = cea_pkg::PH_OP1;
                            do_req     = 1'b1;
                            req_addr   = item.pc;
                        end
                    end
                    default:
                    begin
                        phase_next = cea_pkg::PH_OP1;
                        do_req     = 1'b1;
                        req_addr   = item.pc;
                    end
                endcase
            end
            else
            begin
                unique case (phase_reg)
                    cea_pkg::PH_OP1:
                    begin
                        held_pc_next = 16'(held_pc_reg + 16'd1);
                        unique case (held_mode_reg)
                            cea_pkg::MODE_IMM:
                            begin
                                do_done  = 1'b1;
                                done_ea  = work_address_reg;
                                done_val = {8'h00, b};
                            end
                            cea_pkg::MODE_ZP:
                            begin
                                ar    = 1'b1;
                                ar_ea = {8'h00, b};
                            end
                            cea_pkg::MODE_ZPX:
                            begin
                                ar    = 1'b1;
                                ar_ea = {8'h00, 8'(b + held_x_reg)};
                            end
                            cea_pkg::MODE_ZPY:
                            begin
                                ar    = 1'b1;
                                ar_ea = {8'h00, 8'(b + held_y_reg)};
                            end
                            cea_pkg::MODE_REL:
                            begin
                                sum16 = 16'(held_pc_next
                                            + {{8{(b & cea_pkg::SIGN_MASK) != 8'h00}}, b});
                                carry_next = (sum16 & cea_pkg::PAGE_MASK)
                                             != (held_pc_next & cea_pkg::PAGE_MASK);
                                do_done  = 1'b1;
                                done_ea  = sum16;
                                done_val = sum16;
                            end
                            cea_pkg::MODE_INDX:
                            begin
                                work_address_next = {8'h00, 8'(b + held_x_reg)};
                                phase_next        = cea_pkg::PH_PLO;
                                do_req            = 1'b1;
                                req_addr          = work_address_next;
                            end
                            cea_pkg::MODE_INDY:
                            begin
                                work_address_next = {8'h00, b};
                                phase_next        = cea_pkg::PH_PLO;
                                do_req            = 1'b1;
                                req_addr          = work_address_next;
                            end
                            default:
                            begin
                                low_byte_next = b;
                                phase_next    = cea_pkg::PH_OP2;
                                do_req        = 1'b1;
                                req_addr      = held_pc_next;
                            end
                        endcase
                    end
                    cea_pkg::PH_OP2:
                    begin
                        held_pc_next = 16'(held_pc_reg + 16'd1);
                        base         = {b, low_byte_reg};
                        if (held_mode_reg == cea_pkg::MODE_IND)
                        begin
                            work_address_next = base;
                            phase_next        = cea_pkg::PH_PLO;
                            do_req            = 1'b1;
                            req_addr          = base;
                        end
                        else if (held_mode_reg == cea_pkg::MODE_ABSX
                                 || held_mode_reg == cea_pkg::MODE_ABSY)
                        begin
                            sum16 = 16'(base + {8'h00,
                                    (held_mode_reg == cea_pkg::MODE_ABSX) ? held_x_reg
                                                                          : held_y_reg});
                            carry_next = sum16[15:8] != b;
                            ar         = 1'b1;
                            ar_ea      = sum16;
                        end
                        else
                        begin
                            ar    = 1'b1;
                            ar_ea = base;
                        end
                    end
                    cea_pkg::PH_PLO:
                    begin
                        phase_next = cea_pkg::PH_PHI;
                        do_req     = 1'b1;
                        if (held_mode_reg == cea_pkg::MODE_IND)
                        begin
                            low_byte_next = b;
                            if (fix_wrap)
                            begin
                                req_addr = 16'(work_address_reg + 16'd1);
                            end
                            else
                            begin
                                // Pointer high byte stays on the pointer's page.
                                req_addr = (work_address_reg & cea_pkg::PAGE_MASK)
                                         | (16'(work_address_reg + 16'd1)
                                            & cea_pkg::BYTE_MASK);
                            end
                        end
                        else
                        begin
                            if (held_mode_reg == cea_pkg::MODE_INDY)
                            begin
                                sum9          = {1'b0, b} + {1'b0, held_y_reg};
                                carry_next    = sum9[8];
                                low_byte_next = sum9[7:0];
                            end
                            else
                            begin
                                low_byte_next = b;
                            end
                            req_addr = 16'(work_address_reg + 16'd1) & cea_pkg::BYTE_MASK;
                        end
                    end
                    cea_pkg::PH_PHI:
                    begin
                        hb = (held_mode_reg == cea_pkg::MODE_INDY) ? 8'(b + {7'd0, carry_reg})
                                                                   : b;
                        ar    = 1'b1;
                        ar_ea = {hb, low_byte_reg};
                    end
                    cea_pkg::PH_VAL:
                    begin
                        do_done  = 1'b1;
                        done_ea  = work_address_reg;
                        done_val = {8'h00, b};
                    end
                    default:
                    begin
                        // Read data with no sequence running is dropped.
                    end
                endcase
            end

            if (ar)
            begin
                work_address_next = ar_ea;
                if (held_need_reg)
                begin
                    phase_next = cea_pkg::PH_VAL;
                    do_req     = 1'b1;
                    req_addr   = ar_ea;
                end
                else
                begin
                    do_done = 1'b1;
                    done_ea = ar_ea;
                end
            end

            if (do_done)
            begin
                phase_next = cea_pkg::PH_IDLE;
            end
        end
    end

    always_comb
    begin
        res = '0;
        if (do_done)
        begin
            res.kind              = cea_pkg::OUT_DONE;
            res.effective_address = done_ea;
            res.operand_value     = done_val;
            res.next_pc           = held_pc_next;
            res.page_crossed      = carry_next;
            res.mode_done         = 4'(held_mode_next);
        end
        else if (do_req)
        begin
            res.kind         = cea_pkg::OUT_REQUEST;
            res.read_address = req_addr;
        end
    end

    assign status.busy      = phase_reg != cea_pkg::PH_IDLE;
    assign status.res_valid = do_req || do_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= cea_pkg::PH_IDLE;
            held_mode_reg    <= cea_pkg::MODE_IMP;
            held_pc_reg      <= '0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            held_need_reg    <= 1'b0;
            low_byte_reg     <= '0;
            work_address_reg <= '0;
            carry_reg        <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            held_mode_reg    <= held_mode_next;
            held_pc_reg      <= held_pc_next;
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
            held_need_reg    <= held_need_next;
            low_byte_reg     <= low_byte_next;
            work_address_reg <= work_address_next;
            carry_reg        <= carry_next;
        end
    end

endmodule

>>> hw/rtl/cea_out_stage.sv
// ============================================================================
// cea_out_stage: result register
// Holds one result until the downstream side takes it.
// ============================================================================
module cea_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cea_pkg::result_t  load_res,
    output logic              out_valid,
    input  logic              out_stall,
    output cea_pkg::result_t  out_res,
    output logic              can_load
);

    logic             valid_reg;
    logic             valid_next;
    cea_pkg::result_t res_reg;

    assign can_load  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

>>> hw/rtl/cpu_effective_address_unit.sv
// ============================================================================
// cpu_effective_address_unit: effective-address sequencer for an 8-bit CPU
// Walks the thirteen addressing modes, issuing byte reads and returning the
// effective address, operand value, advanced PC and page-crossing flag.
// ============================================================================
// An accepted request waits in the input register; the combinational
// sequencer step loads its result into the result register. Throughput:
// one request per cycle while no result is stalled downstream, set by the
// single input register and single result register around the sequencer step.
// Reset: rst_n clears the sequencer to idle, empties both registers and sets
// fix_wrap_reg to 0.
// ============================================================================
module cpu_effective_address_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cea_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [cea_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [cea_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    // Request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            item_kind,
    input  logic [3:0]                      mode,
    input  logic [15:0]                     pc,
    input  logic [7:0]                      acc,
    input  logic [7:0]                      index_x,
    input  logic [7:0]                      index_y,
    input  logic                            need_value,
    input  logic [7:0]                      read_data,
    // Result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            out_kind,
    output logic [15:0]                     read_address,
    output logic [15:0]                     effective_address,
    output logic [15:0]                     operand_value,
    output logic [15:0]                     next_pc,
    output logic                            page_crossed,
    output logic [3:0]                      mode_done
);

    // ------------------------------------------------------------------------
    // Configuration register. There is a single register, so only paddr[2]
    // is decoded; the low address bits are the byte offset within the word.
    // ------------------------------------------------------------------------
    logic fix_wrap_reg;
    logic fix_wrap_next;
    logic cfg_write;
    logic cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = paddr[2] == cea_pkg::CFG_IDX_FIX_WRAP;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? {{(cea_pkg::CFG_DATA_W-1){1'b0}}, fix_wrap_reg} : '0;

    always_comb
    begin
        fix_wrap_next = fix_wrap_reg;
        if (cfg_write && cfg_hit)
        begin
            fix_wrap_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_wrap_reg <= 1'b0;
        end
        else
        begin
            fix_wrap_reg <= fix_wrap_next;
        end
    end

    // ------------------------------------------------------------------------
    // Input register. The core takes the held request whenever the result
    // register is empty or is being emptied at the same edge, so requests
    // flow back to back. A result stalled downstream holds the request in
    // the input register, and in_stall stays high until the result leaves.
    // ------------------------------------------------------------------------
    cea_pkg::item_t in_item;
    cea_pkg::item_t held_item;
    logic           held_valid;
    logic           core_fire;
    logic           can_load;

    assign in_item.kind       = item_kind;
    assign in_item.mode       = mode;
    assign in_item.pc         = pc;
    assign in_item.acc        = acc;
    assign in_item.index_x    = index_x;
    assign in_item.index_y    = index_y;
    assign in_item.need_value = need_value;
    assign in_item.read_data  = read_data;

    assign core_fire = held_valid && can_load;

    cea_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (core_fire)
    );

    // ------------------------------------------------------------------------
    // Sequencer core: one step per request. A start request latches the
    // operands and either finishes at once (implied, accumulator, immediate
    // without a fetch) or issues the first operand read. Each read-data
    // request advances the phase and issues the next read or the final
    // result. Read data arriving with no sequence running is dropped and
    // produces nothing.
    // ------------------------------------------------------------------------
    cea_pkg::result_t      core_res;
    cea_pkg::core_status_t core_status;
    cea_pkg::result_t      out_res;

    cea_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (core_fire),
        .item     (held_item),
        .fix_wrap (fix_wrap_reg),
        .res      (core_res),
        .status   (core_status)
    );

    // ------------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------------
    cea_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (core_status.res_valid),
        .load_res  (core_res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .can_load  (can_load)
    );

    assign out_kind          = out_res.kind;
    assign read_address      = out_res.read_address;
    assign effective_address = out_res.effective_address;
    assign operand_value     = out_res.operand_value;
    assign next_pc           = out_res.next_pc;
    assign page_crossed      = out_res.page_crossed;
    assign mode_done         = out_res.mode_done;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The core never steps while a stalled result still occupies the output.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        core_fire |-> !(out_valid && out_stall))
        else $error("core stepped over a stalled result");

    // A finished result always returns the sequencer to idle.
    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.res_valid && core_res.kind == cea_pkg::OUT_DONE |=> !core_status.busy)
        else $error("sequencer still busy after a done result");

    // Page crossing is only reported by the indexed and branch modes.
    a_page_modes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == cea_pkg::OUT_DONE && page_crossed |->
            (mode_done == 4'(cea_pkg::MODE_ABSX) || mode_done == 4'(cea_pkg::MODE_ABSY)
             || mode_done == 4'(cea_pkg::MODE_INDY) || mode_done == 4'(cea_pkg::MODE_REL)))
        else $error("page crossing reported for a mode that never crosses");

    // Read requests carry nothing in the done fields.
    a_request_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == cea_pkg::OUT_REQUEST |->
            effective_address == 16'd0 && next_pc == 16'd0 && mode_done == 4'd0)
        else $error("read request carries done fields");

endmodule
